[rtl/core/ics_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_pkg
// Shared constants and types for the streaming Internet checksum block.
// ----------------------------------------------------------------------------
package ics_pkg;

	// Saturation limit of the region byte counter.
	localparam int MAX_LEN = 2047;
	localparam int COUNT_W = $clog2(MAX_LEN + 1);

	typedef logic [COUNT_W-1:0] count_t;

	// Region kind codes, sampled with the final byte.
	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_UDP   = 2'd1;
	localparam logic [1:0] KIND_TCP   = 2'd2;

	// Protocol numbers added for the pseudo-header.
	localparam logic [15:0] PROTO_UDP = 16'd17;
	localparam logic [15:0] PROTO_TCP = 16'd6;

	// The two 4-byte addresses at the start of the region are not part of the length.
	localparam logic [15:0] LEN_OFFSET = 16'd8;

endpackage

[rtl/core/internet_checksum_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_checksum_stream
// Streaming Internet checksum: one byte per transfer, flagged last byte closes
// the region and one 16-bit checksum comes out. The block takes one byte in
// every cycle unless the input is stalled; a result is formed through the
// input register and the result register in that order, with a single short
// accumulate-and-fold path between them. Odd regions pad the final byte as a
// high byte. With kind UDP or TCP on the last byte the protocol number and the
// byte count minus 8 (count saturating at MAX_LEN) are added. The checksum is
// given in wire order, bits 15..8 first. A pending result that is stalled only
// holds the input when a second last byte reaches the input register.
// ----------------------------------------------------------------------------
module internet_checksum_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic [1:0]  kind,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] checksum_value
);
	import ics_pkg::*;

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [1:0]  kind_s1;

	// Running region state.
	logic [16:0] acc_q;
	logic [7:0]  hold_q;
	logic        odd_q;
	count_t      count_q;

	// Result register.
	logic        out_valid_q;
	logic [15:0] checksum_q;

	logic        advance_s1;
	logic        in_xfer;
	count_t      count_next;
	logic [15:0] word;
	logic [17:0] acc_sum;
	logic [16:0] acc_next;
	logic [15:0] proto_term;
	logic [15:0] len_term;
	logic [18:0] total;
	logic [16:0] fold1;
	logic [16:0] fold2;

	// The input register moves on unless it holds a last byte and the result is still stalled.
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign in_xfer    = in_valid && !in_stall;

	// Saturating byte count including the byte now in the input register.
	assign count_next = (count_q < COUNT_W'(MAX_LEN)) ? count_q + 1'b1 : count_q;

	// Big-endian word: a lone final byte is padded as the high byte.
	assign word = odd_q ? {hold_q, byte_s1} : {byte_s1, 8'h00};

	// Accumulate with one end-around fold.
	assign acc_sum  = {1'b0, acc_q} + {2'b00, word};
	assign acc_next = {1'b0, acc_sum[15:0]} + {15'd0, acc_sum[17:16]};

	// Pseudo-header terms; other kind codes add nothing.
	always_comb begin
		case (kind_s1)
			KIND_UDP: begin
				proto_term = PROTO_UDP;
				len_term   = 16'(count_next) - LEN_OFFSET;
			end
			KIND_TCP: begin
				proto_term = PROTO_TCP;
				len_term   = 16'(count_next) - LEN_OFFSET;
			end
			default: begin
				proto_term = 16'd0;
				len_term   = 16'd0;
			end
		endcase
	end

	// Sum of all final terms, then two end-around folds down to 16 bits.
	assign total = {2'b00, acc_q} + {3'b000, word} + {3'b000, proto_term}
		+ {3'b000, len_term};
	assign fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
	assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
			kind_s1 <= kind;
		end
	end

	// Region state: a last byte returns everything to the start of a region.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			hold_q  <= '0;
			odd_q   <= 1'b0;
			count_q <= '0;
		end else if (advance_s1) begin
			if (last_s1) begin
				acc_q   <= '0;
				hold_q  <= '0;
				odd_q   <= 1'b0;
				count_q <= '0;
			end else if (odd_q) begin
				acc_q   <= acc_next;
				odd_q   <= 1'b0;
				count_q <= count_next;
			end else begin
				hold_q  <= byte_s1;
				odd_q   <= 1'b1;
				count_q <= count_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			checksum_q <= ~fold2[15:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign checksum_value = checksum_q;

endmodule

[rtl/core/ics_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_checker
// Port-level checks for the streaming Internet checksum block.
// ----------------------------------------------------------------------------
module ics_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] checksum_value
);

	// A stalled result stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(checksum_value))
		else $error("stalled result changed or dropped");

	// The input only backs up behind a result that is itself stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

	// A new result follows a last byte transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
		else $error("result without a last byte transfer");

	// A result leaves only through a transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without a transfer");

endmodule

bind internet_checksum_stream ics_checker u_ics_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.last           (last),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.checksum_value (checksum_value)
);
